/* rtl/efaf_pkg.sv */
`default_nettype none

package efaf_pkg;

    // fixed field widths
    localparam int BYTE_W       = 8;
    localparam int LEN_W        = 12;
    localparam int COUNT_W      = 32;
    localparam int PORT_W       = 16;
    localparam int ETYPE_W      = 16;
    localparam int PROTO_W      = 8;
    localparam int ALLOW_W      = 4;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 64;

    // default sizes
    localparam int DEF_PORT_SLOTS    = 8;
    localparam int DEF_MAX_FRAME_LEN = 2048;
    localparam int SLOTS_PER_WORD    = CFG_DATA_W / PORT_W;

    // header byte offsets
    localparam int POS_ETYPE_HI = 12;
    localparam int POS_ETYPE_LO = 13;
    localparam int POS_PROTO    = 23;
    localparam int POS_PORT_HI  = 34;
    localparam int POS_PORT_LO  = 35;
    localparam int MIN_FRAME    = 14;
    localparam int PORT_END     = 36;

    // header codes
    localparam logic [ETYPE_W-1:0] ETH_ARP    = 16'h0806;
    localparam logic [ETYPE_W-1:0] ETH_IPV4   = 16'h0800;
    localparam logic [PROTO_W-1:0] PROTO_ICMP = 8'd1;
    localparam logic [PROTO_W-1:0] PROTO_TCP  = 8'd6;
    localparam logic [PROTO_W-1:0] PROTO_UDP  = 8'd17;

    // bits of protocol_allow
    localparam int ARP_BIT  = 0;
    localparam int ICMP_BIT = 1;
    localparam int TCP_BIT  = 2;
    localparam int UDP_BIT  = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FILTER_ENABLE = 3'd0,
        REG_PROTOCOL_ALLOW = 3'd1,
        REG_TCP_LOWER     = 3'd2,
        REG_TCP_UPPER     = 3'd3,
        REG_UDP_LOWER     = 3'd4,
        REG_UDP_UPPER     = 3'd5
    } cfg_index_t;

    typedef enum logic [1:0] {
        VERDICT_FORWARD  = 2'd0,
        VERDICT_SHORT    = 2'd1,
        VERDICT_FILTERED = 2'd2
    } verdict_t;

    // scalar configuration seen by the decision stage
    typedef struct packed {
        logic               filter_enable;
        logic [ALLOW_W-1:0] protocol_allow;
    } cfg_t;

    // header summary of one finished frame
    typedef struct packed {
        logic [ETYPE_W-1:0] ethertype;
        logic [PROTO_W-1:0] protocol;
        logic [PORT_W-1:0]  port;
        logic               short_frame;
    } frame_sum_t;

endpackage

`default_nettype wire

/* rtl/efaf_cfg.sv */
`default_nettype none

module efaf_cfg
    import efaf_pkg::*;
#(
    parameter int PORT_SLOTS = DEF_PORT_SLOTS
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [CFG_INDEX_W-1:0]             cfg_index,
    input  wire logic [CFG_DATA_W-1:0]              cfg_data,
    output cfg_t                                    cfg,
    output logic      [PORT_SLOTS-1:0][PORT_W-1:0]  tcp_slots,
    output logic      [PORT_SLOTS-1:0][PORT_W-1:0]  udp_slots
);

    logic                              filter_enable_reg;
    logic [ALLOW_W-1:0]                protocol_allow_reg;
    logic [PORT_SLOTS-1:0][PORT_W-1:0] tcp_slots_reg;
    logic [PORT_SLOTS-1:0][PORT_W-1:0] udp_slots_reg;

    // register writes, slots split over a lower and an upper word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_enable_reg  <= 1'b0;
            protocol_allow_reg <= '0;
            tcp_slots_reg      <= '0;
            udp_slots_reg      <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_FILTER_ENABLE:  filter_enable_reg  <= cfg_data[0];
                REG_PROTOCOL_ALLOW: protocol_allow_reg <= cfg_data[ALLOW_W-1:0];
                REG_TCP_LOWER:
                begin
                    for (int k = 0; k < PORT_SLOTS; k++)
                        if (k < SLOTS_PER_WORD)
                            tcp_slots_reg[k] <= cfg_data[PORT_W*(k % SLOTS_PER_WORD) +: PORT_W];
                end
                REG_TCP_UPPER:
                begin
                    for (int k = 0; k < PORT_SLOTS; k++)
                        if (k >= SLOTS_PER_WORD)
                            tcp_slots_reg[k] <= cfg_data[PORT_W*(k % SLOTS_PER_WORD) +: PORT_W];
                end
                REG_UDP_LOWER:
                begin
                    for (int k = 0; k < PORT_SLOTS; k++)
                        if (k < SLOTS_PER_WORD)
                            udp_slots_reg[k] <= cfg_data[PORT_W*(k % SLOTS_PER_WORD) +: PORT_W];
                end
                REG_UDP_UPPER:
                begin
                    for (int k = 0; k < PORT_SLOTS; k++)
                        if (k >= SLOTS_PER_WORD)
                            udp_slots_reg[k] <= cfg_data[PORT_W*(k % SLOTS_PER_WORD) +: PORT_W];
                end
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.filter_enable  = filter_enable_reg;
    assign cfg.protocol_allow = protocol_allow_reg;
    assign tcp_slots          = tcp_slots_reg;
    assign udp_slots          = udp_slots_reg;

endmodule

`default_nettype wire

/* rtl/efaf_parse.sv */
`default_nettype none

module efaf_parse
    import efaf_pkg::*;
#(
    parameter int MAX_FRAME_LEN = DEF_MAX_FRAME_LEN
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [BYTE_W-1:0] frame_byte,
    input  wire logic              last_byte,
    input  wire logic              sum_ready,
    output logic                   sum_valid,
    output frame_sum_t             sum,
    output logic      [LEN_W-1:0]  sum_length
);

    localparam int POS_W = $clog2(MAX_FRAME_LEN + 1);

    logic [POS_W-1:0]   pos_reg;
    logic [ETYPE_W-1:0] ethertype_reg, ethertype_next;
    logic [PROTO_W-1:0] protocol_reg, protocol_next;
    logic [PORT_W-1:0]  port_reg, port_next;
    logic [POS_W-1:0]   length;
    logic               accept;
    logic               sum_valid_reg;
    frame_sum_t         sum_reg, sum_next;
    logic [LEN_W-1:0]   sum_length_reg;

    // one frame summary slot, freed as the decision stage takes it
    assign in_stall = sum_valid_reg && !sum_ready;
    assign accept   = in_valid && !in_stall;

    // header capture including the current byte
    always_comb
    begin
        ethertype_next = ethertype_reg;
        protocol_next  = protocol_reg;
        port_next      = port_reg;
        unique case (pos_reg)
            POS_W'(POS_ETYPE_HI): ethertype_next = {frame_byte, ethertype_reg[BYTE_W-1:0]};
            POS_W'(POS_ETYPE_LO): ethertype_next = {ethertype_reg[ETYPE_W-1:BYTE_W], frame_byte};
            POS_W'(POS_PROTO):    protocol_next  = frame_byte;
            POS_W'(POS_PORT_HI):  port_next      = {frame_byte, port_reg[BYTE_W-1:0]};
            POS_W'(POS_PORT_LO):  port_next      = {port_reg[PORT_W-1:BYTE_W], frame_byte};
            default:
            begin
            end
        endcase
    end

    // length so far, held at the maximum for overlong frames
    assign length = (pos_reg < POS_W'(MAX_FRAME_LEN)) ? pos_reg + 1'b1
                                                      : POS_W'(MAX_FRAME_LEN);

    // summary of the finished frame
    always_comb
    begin
        sum_next.ethertype   = ethertype_next;
        sum_next.protocol    = protocol_next;
        sum_next.port        = (length >= POS_W'(PORT_END)) ? port_next : '0;
        sum_next.short_frame = (length < POS_W'(MIN_FRAME));
    end

    // per-frame parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            ethertype_reg <= '0;
            protocol_reg  <= '0;
            port_reg      <= '0;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                pos_reg       <= '0;
                ethertype_reg <= '0;
                protocol_reg  <= '0;
                port_reg      <= '0;
            end
            else
            begin
                pos_reg       <= length;
                ethertype_reg <= ethertype_next;
                protocol_reg  <= protocol_next;
                port_reg      <= port_next;
            end
        end
    end

    // summary valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sum_valid_reg <= 1'b0;
        else if (accept && last_byte)
            sum_valid_reg <= 1'b1;
        else if (sum_ready)
            sum_valid_reg <= 1'b0;
    end

    // summary payload
    always_ff @(posedge clk)
    begin
        if (accept && last_byte)
        begin
            sum_reg        <= sum_next;
            sum_length_reg <= LEN_W'(length);
        end
    end

    assign sum_valid  = sum_valid_reg;
    assign sum        = sum_reg;
    assign sum_length = sum_length_reg;

endmodule

`default_nettype wire

/* rtl/efaf_decide.sv */
`default_nettype none

module efaf_decide
    import efaf_pkg::*;
#(
    parameter int PORT_SLOTS = DEF_PORT_SLOTS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire cfg_t                              cfg,
    input  wire logic [PORT_SLOTS-1:0][PORT_W-1:0] tcp_slots,
    input  wire logic [PORT_SLOTS-1:0][PORT_W-1:0] udp_slots,
    input  wire logic                              sum_valid,
    input  wire frame_sum_t                        sum,
    input  wire logic [LEN_W-1:0]                  sum_length,
    output logic                                   sum_ready,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic      [1:0]                        verdict,
    output logic      [LEN_W-1:0]                  frame_length,
    output logic      [COUNT_W-1:0]                forwarded_total,
    output logic      [COUNT_W-1:0]                filtered_total
);

    logic               tcp_hit, udp_hit;
    logic               is_arp, is_ipv4;
    logic               allowed;
    logic               load;
    verdict_t           verdict_next;
    logic               out_valid_reg;
    verdict_t           verdict_reg;
    logic [LEN_W-1:0]   frame_length_reg;
    logic [COUNT_W-1:0] forwarded_reg, forwarded_next;
    logic [COUNT_W-1:0] filtered_reg, filtered_next;

    assign sum_ready = !out_valid_reg || !out_stall;
    assign load      = sum_valid && sum_ready;

    // port slot compares, a zero slot matches any port
    always_comb
    begin
        tcp_hit = 1'b0;
        udp_hit = 1'b0;
        for (int k = 0; k < PORT_SLOTS; k++)
        begin
            if (tcp_slots[k] == '0 || tcp_slots[k] == sum.port)
                tcp_hit = 1'b1;
            if (udp_slots[k] == '0 || udp_slots[k] == sum.port)
                udp_hit = 1'b1;
        end
    end

    // protocol rules
    assign is_arp  = (sum.ethertype == ETH_ARP);
    assign is_ipv4 = (sum.ethertype == ETH_IPV4);

    always_comb
    begin
        priority if (!cfg.filter_enable)
            allowed = 1'b1;
        else if (is_arp)
            allowed = cfg.protocol_allow[ARP_BIT];
        else if (is_ipv4 && sum.protocol == PROTO_ICMP)
            allowed = cfg.protocol_allow[ICMP_BIT];
        else if (is_ipv4 && sum.protocol == PROTO_TCP)
            allowed = cfg.protocol_allow[TCP_BIT] && tcp_hit;
        else if (is_ipv4 && sum.protocol == PROTO_UDP)
            allowed = cfg.protocol_allow[UDP_BIT] && udp_hit;
        else
            allowed = 1'b1;
    end

    // verdict and saturating counters
    always_comb
    begin
        forwarded_next = forwarded_reg;
        filtered_next  = filtered_reg;
        priority if (sum.short_frame)
            verdict_next = VERDICT_SHORT;
        else if (allowed)
        begin
            verdict_next = VERDICT_FORWARD;
            if (forwarded_reg != '1)
                forwarded_next = forwarded_reg + 1'b1;
        end
        else
        begin
            verdict_next = VERDICT_FILTERED;
            if (filtered_reg != '1)
                filtered_next = filtered_reg + 1'b1;
        end
    end

    // control state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            forwarded_reg <= '0;
            filtered_reg  <= '0;
        end
        else
        begin
            if (sum_ready)
                out_valid_reg <= sum_valid;
            if (load)
            begin
                forwarded_reg <= forwarded_next;
                filtered_reg  <= filtered_next;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            verdict_reg      <= verdict_next;
            frame_length_reg <= sum_length;
        end
    end

    assign out_valid       = out_valid_reg;
    assign verdict         = verdict_reg;
    assign frame_length    = frame_length_reg;
    assign forwarded_total = forwarded_reg;
    assign filtered_total  = filtered_reg;

endmodule

`default_nettype wire

/* rtl/ethernet_frame_allowlist_filter.sv */
// the result of a frame's last byte goes through the header summary register, then the decision register
// throughput: one byte per cycle while in_stall is low, sustained across frames, set by the
//   single header register and the single decision register that follows it
// a stalled result holds the decision register; bytes keep flowing until a second result waits
// reset (asynchronous, active low) clears configuration, counters, parse state and valids
`default_nettype none

module ethernet_frame_allowlist_filter
    import efaf_pkg::*;
#(
    parameter int PORT_SLOTS    = DEF_PORT_SLOTS,
    parameter int MAX_FRAME_LEN = DEF_MAX_FRAME_LEN
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [BYTE_W-1:0]      frame_byte,
    input  wire logic                   last_byte,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic      [1:0]             verdict,
    output logic      [LEN_W-1:0]       frame_length,
    output logic      [COUNT_W-1:0]     forwarded_total,
    output logic      [COUNT_W-1:0]     filtered_total
);

    cfg_t                              cfg;
    logic [PORT_SLOTS-1:0][PORT_W-1:0] tcp_slots;
    logic [PORT_SLOTS-1:0][PORT_W-1:0] udp_slots;
    logic                              sum_valid;
    logic                              sum_ready;
    frame_sum_t                        sum;
    logic [LEN_W-1:0]                  sum_length;

    // configuration registers
    efaf_cfg #(
        .PORT_SLOTS (PORT_SLOTS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .tcp_slots (tcp_slots),
        .udp_slots (udp_slots)
    );

    // byte parser and header summary register
    efaf_parse #(
        .MAX_FRAME_LEN (MAX_FRAME_LEN)
    ) u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .frame_byte (frame_byte),
        .last_byte  (last_byte),
        .sum_ready  (sum_ready),
        .sum_valid  (sum_valid),
        .sum        (sum),
        .sum_length (sum_length)
    );

    // filter decision, counters and result register
    efaf_decide #(
        .PORT_SLOTS (PORT_SLOTS)
    ) u_decide (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .tcp_slots       (tcp_slots),
        .udp_slots       (udp_slots),
        .sum_valid       (sum_valid),
        .sum             (sum),
        .sum_length      (sum_length),
        .sum_ready       (sum_ready),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .verdict         (verdict),
        .frame_length    (frame_length),
        .forwarded_total (forwarded_total),
        .filtered_total  (filtered_total)
    );

endmodule

`default_nettype wire

/* rtl/efaf_checker.sv */
`default_nettype none

module efaf_checker
    import efaf_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_stall,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire logic [1:0]         verdict,
    input wire logic [LEN_W-1:0]   frame_length,
    input wire logic [COUNT_W-1:0] forwarded_total,
    input wire logic [COUNT_W-1:0] filtered_total
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(verdict) && $stable(frame_length)
            && $stable(forwarded_total) && $stable(filtered_total))
    else $error("stalled result changed");

    // input only stalls behind a waiting result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

    // short verdict agrees with the reported length
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_length != '0 |->
            ((verdict == VERDICT_SHORT) == (frame_length < LEN_W'(MIN_FRAME))))
    else $error("short verdict does not match frame length");

    // the counter of the verdict already includes this frame
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (verdict != VERDICT_FORWARD || forwarded_total != '0)
            && (verdict != VERDICT_FILTERED || filtered_total != '0))
    else $error("counter does not include the reported frame");

    // counters only move together with a new result
    assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(forwarded_total) || !$stable(filtered_total) |-> out_valid)
    else $error("counter moved without a result");

endmodule

bind ethernet_frame_allowlist_filter efaf_checker u_efaf_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .verdict         (verdict),
    .frame_length    (frame_length),
    .forwarded_total (forwarded_total),
    .filtered_total  (filtered_total)
);

`default_nettype wire
